FILE: rtl/lrps_pkg.sv
// Shared types and constants of the latching relay pulse sequencer.
`default_nettype none

package lrps_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 3;
    localparam int TICK_W          = 16;
    localparam int ENTRY_W         = 9;
    localparam int RELAY_NUM_W     = 8;
    localparam int PORT_W          = 8;
    localparam int RELAYS          = 4;
    localparam int QUEUED_W        = 5;

    localparam logic [TICK_W-1:0] PULSE_TICKS_RESET = 16'd400;

    // Register index (byte address / 4)
    localparam logic [ADDR_W-3:0] REG_PULSE_TICKS = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PULSE,
        PH_GAP
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_APPLY,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic apply;
        logic emit;
    } lrps_cmd_t;

    typedef struct packed {
        logic pop_req;
        logic out_free;
    } lrps_status_t;

endpackage

`default_nettype wire

FILE: rtl/latching_relay_pulse_sequencer.sv
// Top level of the latching relay pulse sequencer.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  mode, relay_number, switch_on
//  output    out        out_valid/out_stall  port_value, relay_state, accepted,
//                                            busy_res, queued
//  config    in         APB                  pulse_ticks at byte address 0
//
// A tick or a command that starts nothing goes from accept straight to the result;
// one that pops the command FIFO first passes the registered store read and apply.
// A waiting result holds in the output register; the next transaction is taken
// once it is handed over. Reset clears the FIFO pointers, timer, port and relay
// state at once; no clearing pass is needed.
`default_nettype none

module latching_relay_pulse_sequencer #(
    parameter int QUEUE_DEPTH = lrps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               mode,
    input  wire logic [lrps_pkg::RELAY_NUM_W-1:0]   relay_number,
    input  wire logic [7:0]                         switch_on,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [lrps_pkg::PORT_W-1:0]        port_value,
    output logic      [lrps_pkg::RELAYS-1:0]        relay_state,
    output logic                                    accepted,
    output logic                                    busy_res,
    output logic      [lrps_pkg::QUEUED_W-1:0]      queued,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lrps_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [lrps_pkg::DATA_W-1:0]        pwdata,
    output logic      [lrps_pkg::DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import lrps_pkg::*;

    lrps_cmd_t         cmd;
    lrps_status_t      status;
    logic [TICK_W-1:0] pulse_ticks;

    lrps_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pulse_ticks (pulse_ticks)
    );

    lrps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrps_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pulse_ticks  (pulse_ticks),
        .mode         (mode),
        .relay_number (relay_number),
        .switch_on    (switch_on),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .port_value   (port_value),
        .relay_state  (relay_state),
        .accepted     (accepted),
        .busy_res     (busy_res),
        .queued       (queued)
    );

endmodule

`default_nettype wire

FILE: rtl/lrps_cfg.sv
// APB register file holding pulse_ticks.
`default_nettype none

module lrps_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lrps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lrps_pkg::DATA_W-1:0]   pwdata,
    output logic      [lrps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [lrps_pkg::TICK_W-1:0]   pulse_ticks
);
    import lrps_pkg::*;

    logic [TICK_W-1:0] pulse_ticks_reg;
    logic [TICK_W-1:0] pulse_ticks_next;
    logic              hit;

    assign hit    = (paddr[ADDR_W-1:2] == REG_PULSE_TICKS);
    assign pready = 1'b1;

    always_comb
    begin
        pulse_ticks_next = pulse_ticks_reg;
        if (psel && penable && pwrite && hit)
        begin
            pulse_ticks_next = pwdata[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg <= PULSE_TICKS_RESET;
        end
        else
        begin
            pulse_ticks_reg <= pulse_ticks_next;
        end
    end

    assign prdata      = hit ? DATA_W'(pulse_ticks_reg) : '0;
    assign pulse_ticks = pulse_ticks_reg;

endmodule

`default_nettype wire

FILE: rtl/lrps_ctrl.sv
// Sequencing controller: accept, memory read, apply, result hand-off.
`default_nettype none

module lrps_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire lrps_pkg::lrps_status_t   status,
    output lrps_pkg::lrps_cmd_t           cmd
);
    import lrps_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.pop_req ? ST_READ : ST_EMIT;
                end
            end
            ST_READ:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            ST_READ:  cmd.rd    = 1'b1;
            ST_APPLY: cmd.apply = 1'b1;
            ST_EMIT:  cmd.emit  = status.out_free;
            default:  cmd       = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lrps_dp.sv
// Datapath: command FIFO, pulse/gap timer, coil port, relay state, result register.
`default_nettype none

module lrps_dp #(
    parameter int QUEUE_DEPTH = lrps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lrps_pkg::lrps_cmd_t                cmd,
    output lrps_pkg::lrps_status_t                  status,
    input  wire logic [lrps_pkg::TICK_W-1:0]        pulse_ticks,
    input  wire logic                               mode,
    input  wire logic [lrps_pkg::RELAY_NUM_W-1:0]   relay_number,
    input  wire logic [7:0]                         switch_on,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [lrps_pkg::PORT_W-1:0]        port_value,
    output logic      [lrps_pkg::RELAYS-1:0]        relay_state,
    output logic                                    accepted,
    output logic                                    busy_res,
    output logic      [lrps_pkg::QUEUED_W-1:0]      queued
);
    import lrps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = (PTR_W > QUEUED_W) ? PTR_W : QUEUED_W;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_inc, rd_inc;
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [RELAYS-1:0] relay_reg, relay_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              acc_reg, acc_next;

    logic              out_valid_reg, out_valid_next;
    logic [PORT_W-1:0]   out_port_reg;
    logic [RELAYS-1:0]   out_relay_reg;
    logic                out_acc_reg;
    logic                out_busy_reg;
    logic [QUEUED_W-1:0] out_queued_reg;

    logic              full;
    logic              not_empty;
    logic              tick_end;
    logic              push;
    logic [CNT_W-1:0]  count;

    logic [RELAY_NUM_W-1:0] ent_rel;
    logic [RELAY_NUM_W-1:0] rel_m1;
    logic                   ent_on;
    logic                   rel_ok;
    logic [1:0]             rel_idx;

    assign wr_inc    = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_inc    = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign full      = (wr_inc == rd_ptr_reg);
    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign tick_end  = (tick_reg <= TICK_W'(1));
    assign push      = cmd.take && !mode && !full;

    // A command while idle always leaves the FIFO non-empty, so it always pops.
    assign status.pop_req  = !mode ? (phase_reg == PH_IDLE)
                                   : (phase_reg == PH_GAP && tick_end && not_empty);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign ent_rel = rd_data_reg[ENTRY_W-1:1];
    assign ent_on  = rd_data_reg[0];
    assign rel_m1  = ent_rel - RELAY_NUM_W'(1);
    assign rel_ok  = (ent_rel >= RELAY_NUM_W'(1)) && (ent_rel <= RELAY_NUM_W'(RELAYS));
    assign rel_idx = rel_m1[1:0];

    assign count = (wr_ptr_reg >= rd_ptr_reg)
                 ? CNT_W'(wr_ptr_reg) - CNT_W'(rd_ptr_reg)
                 : CNT_W'(wr_ptr_reg) + CNT_W'(QUEUE_DEPTH) - CNT_W'(rd_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        relay_next  = relay_reg;
        port_next   = port_reg;
        acc_next    = acc_reg;

        if (cmd.take)
        begin
            acc_next = push;
            if (push)
            begin
                wr_ptr_next = wr_inc;
            end
            if (mode && phase_reg != PH_IDLE)
            begin
                if (!tick_end)
                begin
                    tick_next = tick_reg - TICK_W'(1);
                end
                else if (phase_reg == PH_PULSE)
                begin
                    port_next  = '0;
                    phase_next = PH_GAP;
                    tick_next  = pulse_ticks;
                end
                else if (!not_empty)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
        end

        if (cmd.apply)
        begin
            rd_ptr_next = rd_inc;
            phase_next  = PH_PULSE;
            tick_next   = pulse_ticks;
            if (rel_ok)
            begin
                port_next = PORT_W'(1) << {rel_idx, ~ent_on};
                if (ent_on)
                begin
                    relay_next = relay_reg | (RELAYS'(1) << rel_idx);
                end
                else
                begin
                    relay_next = relay_reg & ~(RELAYS'(1) << rel_idx);
                end
            end
        end

        out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            relay_reg     <= '0;
            port_reg      <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            relay_reg     <= relay_next;
            port_reg      <= port_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {relay_number, (switch_on != 8'd0)};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_port_reg   <= port_reg;
            out_relay_reg  <= relay_reg;
            out_acc_reg    <= acc_reg;
            out_busy_reg   <= (phase_reg != PH_IDLE);
            out_queued_reg <= count[QUEUED_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign port_value  = out_port_reg;
    assign relay_state = out_relay_reg;
    assign accepted    = out_acc_reg;
    assign busy_res    = out_busy_reg;
    assign queued      = out_queued_reg;

endmodule

`default_nettype wire

FILE: rtl/lrps_chk.sv
// Port-level checks for the latching relay pulse sequencer, bound to the top.
`default_nettype none

module lrps_chk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [lrps_pkg::PORT_W-1:0]   port_value,
    input  wire logic [lrps_pkg::RELAYS-1:0]   relay_state,
    input  wire logic                          busy_res
);
    import lrps_pkg::*;

    // One transaction in flight: input is held off right after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction is in flight");

    // At most one coil is ever driven.
    a_one_coil: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(port_value))
        else $error("more than one coil driven");

    // With the sequencer idle, no coil is energized.
    a_idle_port_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> port_value == '0)
        else $error("coil driven while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(port_value)
                                   && $stable(relay_state) && $stable(busy_res))
        else $error("stalled result changed");

endmodule

bind latching_relay_pulse_sequencer lrps_chk u_lrps_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .port_value  (port_value),
    .relay_state (relay_state),
    .busy_res    (busy_res)
);

`default_nettype wire
